### design/qclt_pkg.sv
package qclt_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 8;
  localparam int unsigned UsedW  = 16;

  localparam logic [ByteW-1:0] CharLf    = 8'h0A;
  localparam logic [ByteW-1:0] CharCr    = 8'h0D;
  localparam logic [ByteW-1:0] CharNul   = 8'h00;
  localparam logic [ByteW-1:0] CharTab   = 8'h09;
  localparam logic [ByteW-1:0] CharSpace = 8'h20;
  localparam logic [ByteW-1:0] CharBang  = 8'h21;
  localparam logic [ByteW-1:0] CharHash  = 8'h23;
  localparam logic [ByteW-1:0] CharQuote = 8'h22;

  typedef enum logic [2:0] {
    ST_BLANK  = 3'd0,
    ST_WORD   = 3'd1,
    ST_QUOTED = 3'd2,
    ST_SKIP   = 3'd3,
    ST_DONE   = 3'd4
  } state_t;

  typedef enum logic [2:0] {
    CL_BLANK,
    CL_NEWLINE,
    CL_COMMENT,
    CL_QUOTE,
    CL_OTHER
  } class_t;

  typedef enum logic [1:0] {
    END_NONE = 2'd0,
    END_DONE = 2'd1,
    END_DROP = 2'd2
  } end_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_QUOTE = 2'd1,
    ERR_EOL   = 2'd2
  } err_t;

  typedef struct packed {
    logic [ByteW-1:0] byte_in;
    logic             new_line;
  } item_t;

  typedef struct packed {
    logic              char_valid;
    logic [ByteW-1:0]  char_out;
    logic              token_first;
    logic [1:0]        token_end;
    logic              line_done;
    logic [1:0]        error_code;
    logic [CountW-1:0] token_count;
    logic [UsedW-1:0]  bytes_consumed;
  } result_t;

  function automatic class_t classify(input logic [ByteW-1:0] b);
    class_t c;
    c = CL_OTHER;
    if (b inside {CharLf, CharCr, CharNul}) c = CL_NEWLINE;
    else if (b inside {CharTab, CharSpace}) c = CL_BLANK;
    else if (b inside {CharBang, CharHash}) c = CL_COMMENT;
    else if (b == CharQuote) c = CL_QUOTE;
    return c;
  endfunction

endpackage

### design/qclt_stream_if.sv
interface qclt_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

### design/qclt_core.sv
module qclt_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  qclt_pkg::item_t item,
  output qclt_pkg::result_t res
);
  import qclt_pkg::*;

  state_t            parse_state, parse_state_next;
  logic              token_open, token_open_next;
  err_t              error_status, error_status_next;
  logic [CountW-1:0] completed_tokens, completed_tokens_next;
  logic [UsedW-1:0]  consumed_count, consumed_count_next;

  class_t cls;
  logic   cv, first, active;
  end_t   tend;

  assign cls = classify(item.byte_in);

  always_comb begin
    parse_state_next      = parse_state;
    token_open_next       = token_open;
    error_status_next     = error_status;
    completed_tokens_next = completed_tokens;
    consumed_count_next   = consumed_count;
    cv   = 1'b0;
    first = 1'b0;
    tend = END_NONE;

    // new_line drops the old token, then this byte starts the fresh line
    if (item.new_line) begin
      if (token_open) tend = END_DROP;
      parse_state_next      = ST_BLANK;
      token_open_next       = 1'b0;
      error_status_next     = ERR_NONE;
      completed_tokens_next = '0;
      consumed_count_next   = '0;
    end

    active = (parse_state_next == ST_BLANK) || (parse_state_next == ST_WORD) ||
             (parse_state_next == ST_QUOTED) || (parse_state_next == ST_SKIP);

    if (active && (consumed_count_next != {UsedW{1'b1}}))
      consumed_count_next = consumed_count_next + UsedW'(1);

    case (parse_state_next)
      ST_SKIP: begin
        if (cls == CL_NEWLINE) parse_state_next = ST_DONE;
      end
      ST_BLANK: begin
        case (cls)
          CL_COMMENT: parse_state_next = ST_SKIP;
          CL_NEWLINE: parse_state_next = ST_DONE;
          CL_QUOTE:   parse_state_next = ST_QUOTED;
          CL_OTHER: begin
            cv = 1'b1;
            first = 1'b1;
            token_open_next  = 1'b1;
            parse_state_next = ST_WORD;
          end
          default: ;
        endcase
      end
      ST_WORD: begin
        if (cls == CL_OTHER) begin
          cv = 1'b1;
        end else if (cls == CL_QUOTE) begin
          error_status_next = ERR_QUOTE;
          tend = END_DROP;
          token_open_next  = 1'b0;
          parse_state_next = ST_SKIP;
        end else begin
          tend = END_DONE;
          token_open_next = 1'b0;
          if (completed_tokens_next != {CountW{1'b1}})
            completed_tokens_next = completed_tokens_next + CountW'(1);
          if (cls == CL_BLANK) parse_state_next = ST_BLANK;
          else if (cls == CL_NEWLINE) parse_state_next = ST_DONE;
          else parse_state_next = ST_SKIP;
        end
      end
      ST_QUOTED: begin
        if (cls == CL_NEWLINE) begin
          error_status_next = ERR_EOL;
          if (token_open_next) tend = END_DROP;
          token_open_next  = 1'b0;
          parse_state_next = ST_DONE;
        end else if (cls == CL_QUOTE) begin
          // empty quotes never opened a token, so nothing completes
          if (token_open_next) begin
            tend = END_DONE;
            if (completed_tokens_next != {CountW{1'b1}})
              completed_tokens_next = completed_tokens_next + CountW'(1);
          end
          token_open_next  = 1'b0;
          parse_state_next = ST_BLANK;
        end else begin
          cv = 1'b1;
          if (!token_open_next) first = 1'b1;
          token_open_next = 1'b1;
        end
      end
      default: ;
    endcase

    res.char_valid     = cv;
    res.char_out       = cv ? item.byte_in : '0;
    res.token_first    = first;
    res.token_end      = tend;
    res.line_done      = !((parse_state_next == ST_BLANK) || (parse_state_next == ST_WORD) ||
                           (parse_state_next == ST_QUOTED) || (parse_state_next == ST_SKIP));
    res.error_code     = error_status_next;
    res.token_count    = completed_tokens_next;
    res.bytes_consumed = consumed_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state      <= ST_BLANK;
      token_open       <= 1'b0;
      error_status     <= ERR_NONE;
      completed_tokens <= '0;
      consumed_count   <= '0;
    end else if (step) begin
      parse_state      <= parse_state_next;
      token_open       <= token_open_next;
      error_status     <= error_status_next;
      completed_tokens <= completed_tokens_next;
      consumed_count   <= consumed_count_next;
    end
  end

endmodule

### design/quoted_command_line_tokenizer.sv
// Command line tokenizer, one byte per item.
// cmd (sink): byte_in and new_line. Bytes are classed as newline, blank,
//   comment mark, double quote or other; new_line clears the parser before
//   its byte is handled.
// tok (source): one result item per byte: streamed token character with
//   first mark, token completed/discarded mark, done flag, sticky error,
//   token count and consumed byte count.
// Path: an accepted item is held in the input register, then runs through
//   the parser into the result register and is offered on tok from then on.
// Throughput: one item per cycle while tok takes results; the parser state
//   update is combinational logic between the input and result registers.
// Reset (rst, synchronous): parser state, counters and both valid flags
//   clear; cmd.ready is held low during reset and rises once reset drops.
// Stall: while tok is not taken the result register holds; the input
//   register still takes one more item, then cmd.ready drops until the
//   result leaves.
module quoted_command_line_tokenizer (
  input logic          clk,
  input logic          rst,
  qclt_stream_if.sink   cmd,
  qclt_stream_if.source tok
);
  import qclt_pkg::*;

  logic    in_valid;
  item_t   in_item;
  logic    out_valid;
  result_t out_res;
  result_t step_res;
  logic    advance;

  assign advance   = in_valid && (!out_valid || tok.ready);
  assign cmd.ready = !rst && (!in_valid || advance);
  assign tok.valid = out_valid;
  assign tok.data  = out_res;

  qclt_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (in_item),
    .res  (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) in_item <= cmd.data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (tok.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_res <= step_res;
  end

`ifndef SYNTHESIS
  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("parsed item did not reach result register");

  a_input_holds: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(in_item)))
    else $error("waiting input item lost or changed");

  a_no_char_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_res.char_valid) |-> (out_res.char_out == '0 && !out_res.token_first))
    else $error("character fields set without a character");

  a_eol_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.error_code == ERR_EOL) |-> out_res.line_done)
    else $error("end of line error without done");
`endif

endmodule

### bench/tb_quoted_command_line_tokenizer.sv
module tb_quoted_command_line_tokenizer;
  import qclt_pkg::*;

  logic clk = 1'b0;
  logic rst;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  qclt_stream_if #(.payload_t(item_t))   cmd_if ();
  qclt_stream_if #(.payload_t(result_t)) tok_if ();

  quoted_command_line_tokenizer uut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_if),
    .tok(tok_if)
  );

  // tokenizer state as predicted
  state_t         cur_state;
  logic           tok_open_now;
  err_t           line_err;
  logic [7:0]     done_tokens;
  logic [15:0]    used_bytes;

  result_t        expected_q[$];

  bit             src_idle_on;
  bit             sink_idle_on;
  bit             hold_request;
  int             sink_wait;

  int fail_count;
  int checked_count;
  int live_count;
  int ignored_count;
  int line_starts;
  int tokens_done;
  int tokens_dropped;
  int quote_errs;
  int eol_errs;

  function automatic class_t kind_of(input logic [7:0] b);
    class_t k;
    case (b)
      CharLf, CharCr, CharNul: k = CL_NEWLINE;
      CharTab, CharSpace:      k = CL_BLANK;
      CharBang, CharHash:      k = CL_COMMENT;
      CharQuote:               k = CL_QUOTE;
      default:                 k = CL_OTHER;
    endcase
    return k;
  endfunction

  function automatic void clear_line_state();
    cur_state    = ST_BLANK;
    tok_open_now = 1'b0;
    line_err     = ERR_NONE;
    done_tokens  = '0;
    used_bytes   = '0;
  endfunction

  function automatic void count_token();
    if (done_tokens != 8'hFF) done_tokens++;
  endfunction

  // Advances the tokenizer state by one byte and returns its result item.
  function automatic result_t tokenize_byte(input item_t it);
    result_t r;
    class_t  k;
    r = '0;
    if (it.new_line) begin
      if (tok_open_now) r.token_end = END_DROP;
      clear_line_state();
      line_starts++;
    end
    if (cur_state < ST_DONE) begin
      live_count++;
      if (used_bytes != 16'hFFFF) used_bytes++;
      k = kind_of(it.byte_in);
      case (cur_state)
        ST_SKIP: begin
          if (k == CL_NEWLINE) cur_state = ST_DONE;
        end
        ST_BLANK: begin
          case (k)
            CL_COMMENT: cur_state = ST_SKIP;
            CL_NEWLINE: cur_state = ST_DONE;
            CL_QUOTE:   cur_state = ST_QUOTED;
            CL_OTHER: begin
              r.char_valid  = 1'b1;
              r.token_first = 1'b1;
              tok_open_now  = 1'b1;
              cur_state     = ST_WORD;
            end
            default: ;
          endcase
        end
        ST_WORD: begin
          if (k == CL_OTHER) begin
            r.char_valid = 1'b1;
          end else if (k == CL_QUOTE) begin
            line_err     = ERR_QUOTE;
            r.token_end  = END_DROP;
            tok_open_now = 1'b0;
            cur_state    = ST_SKIP;
          end else begin
            r.token_end  = END_DONE;
            tok_open_now = 1'b0;
            count_token();
            if (k == CL_BLANK) cur_state = ST_BLANK;
            else if (k == CL_NEWLINE) cur_state = ST_DONE;
            else cur_state = ST_SKIP;
          end
        end
        default: begin
          if (k == CL_NEWLINE) begin
            line_err = ERR_EOL;
            if (tok_open_now) r.token_end = END_DROP;
            tok_open_now = 1'b0;
            cur_state    = ST_DONE;
          end else if (k == CL_QUOTE) begin
            // empty quotes close without any token mark
            if (tok_open_now) begin
              r.token_end = END_DONE;
              count_token();
            end
            tok_open_now = 1'b0;
            cur_state    = ST_BLANK;
          end else begin
            r.char_valid  = 1'b1;
            r.token_first = !tok_open_now;
            tok_open_now  = 1'b1;
          end
        end
      endcase
      if (line_err == ERR_QUOTE && r.token_end == END_DROP && k == CL_QUOTE) quote_errs++;
      if (line_err == ERR_EOL && cur_state == ST_DONE && k == CL_NEWLINE) eol_errs++;
    end else begin
      ignored_count++;
    end
    r.char_out       = r.char_valid ? it.byte_in : 8'h00;
    r.line_done      = (cur_state >= ST_DONE);
    r.error_code     = line_err;
    r.token_count    = done_tokens;
    r.bytes_consumed = used_bytes;
    if (r.token_end == END_DONE) tokens_done++;
    if (r.token_end == END_DROP) tokens_dropped++;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 20) $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic compare_result(input result_t got, input result_t want);
    string tag;
    tag = $sformatf("result %0d", checked_count);
    if (got.char_valid !== want.char_valid)
      report_mismatch($sformatf("%s char_valid got %0d want %0d", tag,
                                got.char_valid, want.char_valid));
    if (got.char_out !== want.char_out)
      report_mismatch($sformatf("%s char_out got %0h want %0h", tag,
                                got.char_out, want.char_out));
    if (got.token_first !== want.token_first)
      report_mismatch($sformatf("%s token_first got %0d want %0d", tag,
                                got.token_first, want.token_first));
    if (got.token_end !== want.token_end)
      report_mismatch($sformatf("%s token_end got %0d want %0d", tag,
                                got.token_end, want.token_end));
    if (got.line_done !== want.line_done)
      report_mismatch($sformatf("%s line_done got %0d want %0d", tag,
                                got.line_done, want.line_done));
    if (got.error_code !== want.error_code)
      report_mismatch($sformatf("%s error_code got %0d want %0d", tag,
                                got.error_code, want.error_code));
    if (got.token_count !== want.token_count)
      report_mismatch($sformatf("%s token_count got %0d want %0d", tag,
                                got.token_count, want.token_count));
    if (got.bytes_consumed !== want.bytes_consumed)
      report_mismatch($sformatf("%s bytes_consumed got %0d want %0d", tag,
                                got.bytes_consumed, want.bytes_consumed));
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && tok_if.valid && tok_if.ready) begin
      sink_wait = sink_idle_on ? $urandom_range(0, 15) : 0;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with none expected", checked_count));
      end else begin
        compare_result(tok_if.data, expected_q.pop_front());
      end
      checked_count++;
    end
  end

  // receiver: per-item wait, plus a long hold on request
  initial tok_if.ready = 1'b0;
  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      sink_wait = 400;
    end
    if (sink_wait > 0) begin
      sink_wait--;
      tok_if.ready <= 1'b0;
    end else begin
      tok_if.ready <= 1'b1;
    end
  end

  // Starts and ends at a falling edge; valid stays high after acceptance.
  task automatic send_item(input logic [7:0] b, input logic nl);
    int    gap;
    item_t it;
    gap = src_idle_on ? $urandom_range(0, 15) : 0;
    repeat (gap) begin
      cmd_if.valid <= 1'b0;
      @(negedge clk);
    end
    it.byte_in  = b;
    it.new_line = nl;
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= it;
    do @(posedge clk); while (!cmd_if.ready);
    expected_q.push_back(tokenize_byte(it));
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input logic first_nl);
    for (int i = 0; i < s.len(); i++) send_item(s[i], first_nl && i == 0);
  endtask

  task automatic wait_drained();
    cmd_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_other();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (kind_of(b) != CL_OTHER);
    return b;
  endfunction

  function automatic logic [7:0] pick_quoted_char();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (kind_of(b) == CL_NEWLINE || kind_of(b) == CL_QUOTE);
    return b;
  endfunction

  function automatic logic [7:0] pick_newline();
    logic [7:0] b;
    case ($urandom_range(0, 2))
      0:       b = CharLf;
      1:       b = CharCr;
      default: b = CharNul;
    endcase
    return b;
  endfunction

  task automatic test_words();
    send_text("ab\tc ", 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(CharCr, 1'b0);
    send_item(8'h7E, 1'b1);
    send_item(CharNul, 1'b0);
  endtask

  task automatic test_quotes();
    // blank and comment mark inside quotes, then empty quotes, then adjacent
    send_text("\"a #\"\"\"\"q\"\n", 1'b1);
  endtask

  task automatic test_comments();
    send_text("w!x\n", 1'b1);
    send_text(" #\"y\n", 1'b1);
  endtask

  task automatic test_quote_in_word();
    // trailing bytes after the newline are ignored
    send_text("a\"b\nc", 1'b1);
  endtask

  task automatic test_newline_in_quotes();
    send_text("\"a\n", 1'b1);
    send_item(CharQuote, 1'b1);
    send_item(CharNul, 1'b0);
  endtask

  task automatic test_restart_open_token();
    send_text("ab", 1'b1);
    send_text("c\"d", 1'b1);
    send_text("e\n", 1'b1);
  endtask

  task automatic test_token_count_limit();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    send_item(CharSpace, 1'b1);
    repeat (260) begin
      send_item(pick_other(), 1'b0);
      send_item(CharTab, 1'b0);
    end
    send_item(CharLf, 1'b0);
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    cmd_if.valid <= 1'b0;
    @(posedge clk);
    hold_request = 1'b1;
    @(negedge clk);
    send_text("long \"quoted run\" word\n", 1'b1);
    wait_drained();
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  task automatic random_line();
    logic [7:0] line_q[$];
    int         ntok;
    int         len;
    int         idx;
    bit         noisy;
    noisy = ($urandom_range(0, 4) == 0);
    ntok  = $urandom_range(0, 6);
    for (int i = 0; i < ntok; i++) begin
      repeat ((i == 0) ? $urandom_range(0, 2) : $urandom_range(1, 3))
        line_q.push_back($urandom_range(0, 1) ? CharTab : CharSpace);
      if ($urandom_range(0, 2) == 0) begin
        line_q.push_back(CharQuote);
        len = $urandom_range(0, 6);
        repeat (len) line_q.push_back(pick_quoted_char());
        line_q.push_back(CharQuote);
      end else begin
        len = $urandom_range(1, 6);
        repeat (len) line_q.push_back(pick_other());
      end
    end
    if ($urandom_range(0, 4) == 0) begin
      line_q.push_back($urandom_range(0, 1) ? CharBang : CharHash);
      repeat ($urandom_range(0, 5)) line_q.push_back(pick_quoted_char());
    end
    // some lines stay open so the next line start cuts them off
    if ($urandom_range(0, 4) != 0) begin
      line_q.push_back(pick_newline());
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) line_q.push_back(8'($urandom_range(0, 255)));
    end
    if (line_q.size() == 0) line_q.push_back(pick_newline());
    if (noisy) begin
      repeat ($urandom_range(1, 3)) begin
        idx = $urandom_range(0, line_q.size() - 1);
        case ($urandom_range(0, 2))
          0:       line_q[idx] = CharQuote;
          1:       line_q[idx] = pick_newline();
          default: line_q[idx] = 8'($urandom_range(0, 255));
        endcase
      end
    end
    foreach (line_q[i])
      send_item(line_q[i], i == 0 || (noisy && $urandom_range(0, 15) == 0));
  endtask

  task automatic test_random();
    int start;
    start = live_count;
    while (live_count - start < 560) begin
      src_idle_on  = ($urandom_range(0, 2) != 0);
      sink_idle_on = ($urandom_range(0, 2) != 0);
      random_line();
    end
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  initial begin
    #8_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    rst          = 1'b1;
    cmd_if.valid = 1'b0;
    cmd_if.data  = '0;
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    hold_request = 1'b0;
    sink_wait    = 0;
    clear_line_state();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_words();
    test_quotes();
    test_comments();
    test_quote_in_word();
    test_newline_in_quotes();
    test_restart_open_token();
    test_backpressure();
    test_token_count_limit();
    test_random();
    wait_drained();

    $display("Covered %0d parsed bytes, %0d ignored after line end, %0d line starts;",
             live_count, ignored_count, line_starts);
    $display("%0d checked. Tokens: %0d completed, %0d dropped; %0d quote, %0d eol errors.",
             checked_count, tokens_done, tokens_dropped, quote_errs, eol_errs);
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
